// ===== rtl/mandelbrot_escape_pixel_assert.svh =====
// Assertion macros shared by the escape pixel RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MBE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbe_pkg.sv =====
// Package of the Mandelbrot escape pixel block: widths, beat types,
// register indexes and the divider and saturation helpers.
// Has no dependencies.
package mbe_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 16;

  localparam int PIX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int ITER_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Q_W        = 32;
  localparam int QUO_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int DIV_STEPS  = QUO_BITS;
  localparam int ACC_W      = 2 * Q_W - FRAC_BITS + 3;
  localparam int MAP_W      = ((QUO_BITS > Q_W) ? QUO_BITS : Q_W) + 2;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [DIM_W-1:0]        dim_t;
  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [QUO_BITS-1:0]     quo_t;
  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [MAP_W-1:0] map_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_ROWS     = 2'd0,
    CFG_IMAGE_COLUMNS  = 2'd1,
    CFG_MAX_ITERATIONS = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_row;
    logic [PIX_W-1:0] pixel_column;
  } pixel_in_t;

  typedef struct packed {
    logic              pixel_inside;
    logic [ITER_W-1:0] iteration_count;
  } pixel_out_t;

  typedef struct packed {
    dim_t rem;
    quo_t nq;
  } div_lane_t;

  typedef struct packed {
    div_lane_t re;
    div_lane_t im;
  } div_pair_t;

  typedef struct packed {
    q_t cx;
    q_t cy;
  } coord_pair_t;

  localparam q_t   Q_MAX    = q_t'({1'b0, {(Q_W-1){1'b1}}});
  localparam q_t   Q_MIN    = q_t'({1'b1, {(Q_W-1){1'b0}}});
  localparam acc_t ACC_QMAX = acc_t'(Q_MAX);
  localparam acc_t ACC_QMIN = acc_t'(Q_MIN);
  localparam map_t MAP_QMAX = map_t'(Q_MAX);
  localparam acc_t FOUR     = acc_t'(1) <<< (FRAC_BITS + 2);
  localparam quo_t OFF_RE   = quo_t'(3) << (FRAC_BITS - 1);
  localparam quo_t OFF_IM   = quo_t'(1) << FRAC_BITS;

  // One restoring division step; quotient bits replace the numerator bits.
  function automatic div_lane_t div_step(div_lane_t l, dim_t d);
    logic [DIM_W:0] t;
    div_lane_t      r;
    t    = {l.rem, l.nq[QUO_BITS-1]};
    r.nq = {l.nq[QUO_BITS-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem   = DIM_W'(t - {1'b0, d});
      r.nq[0] = 1'b1;
    end else begin
      r.rem = t[DIM_W-1:0];
    end
    return r;
  endfunction

  function automatic q_t map_coord(quo_t q, quo_t off);
    map_t diff;
    diff = map_t'(q) - map_t'(off);
    if (diff > MAP_QMAX) begin
      return Q_MAX;
    end
    return q_t'(diff);
  endfunction

  function automatic q_t sat_q(acc_t v);
    if (v > ACC_QMAX) begin
      return Q_MAX;
    end
    if (v < ACC_QMIN) begin
      return Q_MIN;
    end
    return q_t'(v);
  endfunction

endpackage

// ===== rtl/mandelbrot_escape_pixel.sv =====
// Top level of the Mandelbrot escape pixel block: configuration registers,
// divider chain and escape core. Depends on mbe_pkg, mbe_div_chain, mbe_escape_core.
//
//   channel   direction  handshake                 beat
//   in        input      in_valid_i / in_ready_o   pixel_row, pixel_column
//   out       output     out_valid_o / out_ready_i pixel_inside, iteration_count
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// In the escape core a pixel passes through MUL and UPD once for each iteration that it counts,
// and once more when it escapes, before OUT: each iteration goes through the three 32x32
// multipliers in MUL and is applied in UPD.
// Mapping to c runs through a 41-cell divider chain and its hold register, overlapped with the
// core's work on the previous pixel. Reset is asynchronous and needs no clearing pass.
// A stalled result waits in the output register while the next pixel is taken in.
module mandelbrot_escape_pixel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  mbe_pkg::pixel_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output mbe_pkg::pixel_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  mbe_pkg::dim_t          rows_q, cols_q;
  logic [mbe_pkg::ITER_W-1:0] max_iter_q;
  logic                   coord_valid;
  logic                   coord_ready;
  mbe_pkg::coord_pair_t   coord;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= mbe_pkg::dim_t'(64);
      cols_q     <= mbe_pkg::dim_t'(64);
      max_iter_q <= mbe_pkg::ITER_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mbe_pkg::CFG_IMAGE_ROWS:     rows_q     <= cfg_data_i[mbe_pkg::DIM_W-1:0];
        mbe_pkg::CFG_IMAGE_COLUMNS:  cols_q     <= cfg_data_i[mbe_pkg::DIM_W-1:0];
        mbe_pkg::CFG_MAX_ITERATIONS: max_iter_q <= cfg_data_i[mbe_pkg::ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_div_chain u_chain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .row_i         (mbe_pkg::coord_t'(in_data_i.pixel_row)),
    .col_i         (mbe_pkg::coord_t'(in_data_i.pixel_column)),
    .rows_i        (rows_q),
    .cols_i        (cols_q),
    .coord_valid_o (coord_valid),
    .coord_ready_i (coord_ready),
    .coord_o       (coord)
  );

  mbe_escape_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_valid_i (coord_valid),
    .start_ready_o (coord_ready),
    .start_i       (coord),
    .limit_i       (mbe_pkg::count_t'(max_iter_q)),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ===== rtl/mbe_div_cell.sv =====
// One cell of the coordinate divider chain: a restoring step for both lanes.
// Depends on mbe_pkg.
module mbe_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  mbe_pkg::div_pair_t data_i,
  input  mbe_pkg::dim_t     div_re_i,
  input  mbe_pkg::dim_t     div_im_i,
  output logic              valid_o,
  output mbe_pkg::div_pair_t data_o
);

  logic               valid_q;
  mbe_pkg::div_pair_t data_q;
  mbe_pkg::div_pair_t data_d;

  always_comb begin
    data_d.re = mbe_pkg::div_step(data_i.re, div_re_i);
    data_d.im = mbe_pkg::div_step(data_i.im, div_im_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/mbe_div_chain.sv =====
// Divider chain that maps a pixel index pair to the point c, plus its hold
// register. Depends on mbe_pkg, mbe_div_cell and the assertion header.
`include "mandelbrot_escape_pixel_assert.svh"

module mbe_div_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mbe_pkg::coord_t      row_i,
  input  mbe_pkg::coord_t      col_i,
  input  mbe_pkg::dim_t        rows_i,
  input  mbe_pkg::dim_t        cols_i,
  output logic                 coord_valid_o,
  input  logic                 coord_ready_i,
  output mbe_pkg::coord_pair_t coord_o
);

  logic [mbe_pkg::DIV_STEPS:0] valid_w;
  mbe_pkg::div_pair_t          data_w [mbe_pkg::DIV_STEPS+1];
  mbe_pkg::dim_t               div_re;
  mbe_pkg::dim_t               div_im;
  logic                        busy_q, busy_d;
  logic                        hold_valid_q, hold_valid_d;
  mbe_pkg::coord_pair_t        hold_q;
  logic                        accept;
  logic                        taken;

  assign div_re = (cols_i == '0) ? mbe_pkg::dim_t'(1) : cols_i;
  assign div_im = (rows_i == '0) ? mbe_pkg::dim_t'(1) : rows_i;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign taken      = hold_valid_q && coord_ready_i;

  assign valid_w[0]       = accept;
  assign data_w[0].re.rem = '0;
  assign data_w[0].re.nq  = mbe_pkg::quo_t'(col_i) << (mbe_pkg::FRAC_BITS + 1);
  assign data_w[0].im.rem = '0;
  assign data_w[0].im.nq  = mbe_pkg::quo_t'(row_i) << (mbe_pkg::FRAC_BITS + 1);

  for (genvar g = 0; g < mbe_pkg::DIV_STEPS; g++) begin : g_cell
    mbe_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_w[g]),
      .data_i   (data_w[g]),
      .div_re_i (div_re),
      .div_im_i (div_im),
      .valid_o  (valid_w[g+1]),
      .data_o   (data_w[g+1])
    );
  end

  always_comb begin
    busy_d       = busy_q;
    hold_valid_d = hold_valid_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (valid_w[mbe_pkg::DIV_STEPS]) begin
      hold_valid_d = 1'b1;
    end
    if (taken) begin
      hold_valid_d = 1'b0;
      busy_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_w[mbe_pkg::DIV_STEPS]) begin
      hold_q.cx <= mbe_pkg::map_coord(data_w[mbe_pkg::DIV_STEPS].re.nq, mbe_pkg::OFF_RE);
      hold_q.cy <= mbe_pkg::map_coord(data_w[mbe_pkg::DIV_STEPS].im.nq, mbe_pkg::OFF_IM);
    end
  end

  assign coord_valid_o = hold_valid_q;
  assign coord_o       = hold_q;

  `MBE_ASSERT_IMPL(a_hold_free, valid_w[mbe_pkg::DIV_STEPS], !hold_valid_q, "hold overrun")
  `MBE_ASSERT_IMPL(a_hold_busy, hold_valid_q, busy_q, "hold valid while chain idle")
  `MBE_ASSERT_NEXT(a_accept_empty, accept, busy_q && !hold_valid_q, "accept while occupied")

endmodule

// ===== rtl/mbe_escape_core.sv =====
// Escape-time iteration core: squares z, tests |z|^2 against 4 and counts.
// Depends on mbe_pkg and the assertion header.
`include "mandelbrot_escape_pixel_assert.svh"

module mbe_escape_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_valid_i,
  output logic                 start_ready_o,
  input  mbe_pkg::coord_pair_t start_i,
  input  mbe_pkg::count_t      limit_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mbe_pkg::pixel_out_t  out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_OUT  = 4'b1000
  } core_state_e;

  core_state_e                 state_q, state_d;
  mbe_pkg::q_t                 x_q, x_d, y_q, y_d;
  mbe_pkg::q_t                 cx_q, cx_d, cy_q, cy_d;
  mbe_pkg::count_t             n_q, n_d, limit_q, limit_d;
  logic signed [2*mbe_pkg::Q_W-1:0] pxx_q, pyy_q, pxy_q;
  mbe_pkg::acc_t               x2, y2, xy2, mag, nx, ny;
  mbe_pkg::count_t             n_inc;
  logic                        out_valid_q, out_valid_d;
  mbe_pkg::pixel_out_t         out_q;
  logic                        out_load;

  assign x2    = mbe_pkg::ACC_W'(pxx_q >>> mbe_pkg::FRAC_BITS);
  assign y2    = mbe_pkg::ACC_W'(pyy_q >>> mbe_pkg::FRAC_BITS);
  assign xy2   = mbe_pkg::ACC_W'(pxy_q >>> (mbe_pkg::FRAC_BITS - 1));
  assign mag   = x2 + y2;
  assign nx    = x2 - y2 + mbe_pkg::acc_t'(cx_q);
  assign ny    = xy2 + mbe_pkg::acc_t'(cy_q);
  assign n_inc = n_q + mbe_pkg::count_t'(1);

  assign start_ready_o = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_d   = out_load || (out_valid_q && !out_ready_i);

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    n_d     = n_q;
    limit_d = limit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_valid_i) begin
          x_d     = '0;
          y_d     = '0;
          n_d     = '0;
          cx_d    = start_i.cx;
          cy_d    = start_i.cy;
          limit_d = limit_i;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (mag >= mbe_pkg::FOUR) begin
          state_d = ST_OUT;
        end else if (n_inc >= limit_q) begin
          n_d     = n_inc;
          state_d = ST_OUT;
        end else begin
          n_d     = n_inc;
          x_d     = mbe_pkg::sat_q(nx);
          y_d     = mbe_pkg::sat_q(ny);
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    n_q     <= n_d;
    limit_q <= limit_d;
    pxx_q   <= x_q * x_q;
    pyy_q   <= y_q * y_q;
    pxy_q   <= x_q * y_q;
    if (out_load) begin
      out_q.pixel_inside    <= (n_q == limit_q);
      out_q.iteration_count <= mbe_pkg::ITER_W'(n_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MBE_ASSERT_IMPL(a_count_below_limit, state_q == ST_MUL, (n_q < limit_q) || (n_q == '0), "count ran past limit")
  `MBE_ASSERT_NEXT(a_out_wait, (state_q == ST_OUT) && out_valid_q && !out_ready_i, state_q == ST_OUT, "result dropped")
  `MBE_ASSERT_IMPL(a_final_nonzero, state_q == ST_OUT, n_q != '0, "final count is zero")

endmodule
